// ===== hdl/simt_divergence_mask_stack_core_defines.svh =====
// ---------------------------------------------------------------------------
// simt_divergence_mask_stack_core_defines.svh
// Assertion macros shared by the mask stack RTL.
// ---------------------------------------------------------------------------
`ifndef SIMT_DIVERGENCE_MASK_STACK_CORE_DEFINES_SVH
`define SIMT_DIVERGENCE_MASK_STACK_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SDMS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sdms assertion failed");
`define SDMS_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("sdms forbidden condition");
`else
`define SDMS_ASSERT(lbl, clk, rst_n, prop)
`define SDMS_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== hdl/sdms_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdms_pkg
// Shared constants, beat layout and controller/datapath interface types.
// ---------------------------------------------------------------------------
package sdms_pkg;

	localparam int NUM_WARPS_DEF   = 16;
	localparam int WARP_WIDTH_DEF  = 32;
	localparam int STACK_DEPTH_DEF = 32;

	localparam int CMD_W   = 3;
	localparam int WARP_W  = 4;
	localparam int COND_W  = 32;
	localparam int TCNT_W  = 6;
	localparam int TIDX_W  = 5;
	localparam int MASK_W  = 32;
	localparam int CNT_W   = 32;
	localparam int DEPTH_W = 6;
	localparam int CFG_W   = 6;

	localparam logic [CFG_W-1:0] CFG_DEPTH_RST = 6'd32;

	localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_BRANCH  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_JOIN    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

	// input beat offsets
	localparam int IN_CMD_LO  = 0;
	localparam int IN_WARP_LO = IN_CMD_LO + CMD_W;
	localparam int IN_COND_LO = IN_WARP_LO + WARP_W;
	localparam int IN_TCNT_LO = IN_COND_LO + COND_W;
	localparam int IN_TIDX_LO = IN_TCNT_LO + TCNT_W;
	localparam int IN_BITS    = IN_TIDX_LO + TIDX_W;
	localparam int S_DATA_W   = ((IN_BITS + 7) / 8) * 8;

	// output beat offsets
	localparam int OUT_MASK_LO  = 0;
	localparam int OUT_TACT_LO  = OUT_MASK_LO + MASK_W;
	localparam int OUT_OK_LO    = OUT_TACT_LO + 1;
	localparam int OUT_DIV_LO   = OUT_OK_LO + 1;
	localparam int OUT_TOTAL_LO = OUT_DIV_LO + 1;
	localparam int OUT_DEPTH_LO = OUT_TOTAL_LO + CNT_W;
	localparam int OUT_BITS     = OUT_DEPTH_LO + DEPTH_W;
	localparam int M_DATA_W     = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic pop;
		logic load_out;
	} sdms_cmd_t;

	typedef struct packed {
		logic pop_req;
	} sdms_sts_t;

endpackage

// ===== hdl/sdms_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdms_ctrl
// Sequencer: accept, execute, optional stack pop, result hand-off.
// ---------------------------------------------------------------------------
`include "simt_divergence_mask_stack_core_defines.svh"

module sdms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  sdms_pkg::sdms_sts_t sts,
	output sdms_pkg::sdms_cmd_t cmd
);
	import sdms_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = sts.pop_req ? ST_POP : ST_DONE;
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	`SDMS_ASSERT(a_accept_exec, clk, arst_n, (s_tvalid && s_tready) |=> (state_q == ST_EXEC))
	`SDMS_ASSERT(a_pop_from_exec, clk, arst_n, (state_q == ST_POP) |-> ($past(state_q) == ST_EXEC))

endmodule

// ===== hdl/sdms_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdms_dp
// Per-warp records, saved-mask memory, divergence counter, result register.
// ---------------------------------------------------------------------------
`include "simt_divergence_mask_stack_core_defines.svh"

module sdms_dp #(
	parameter int NUM_WARPS   = sdms_pkg::NUM_WARPS_DEF,
	parameter int WARP_WIDTH  = sdms_pkg::WARP_WIDTH_DEF,
	parameter int STACK_DEPTH = sdms_pkg::STACK_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sdms_pkg::S_DATA_W-1:0] s_tdata,
	output logic [sdms_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                          cfg_wr_en,
	input  logic [sdms_pkg::CFG_W-1:0]    cfg_wr_data,
	input  sdms_pkg::sdms_cmd_t           cmd,
	output sdms_pkg::sdms_sts_t           sts
);
	import sdms_pkg::*;

	localparam int WIDX = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1;
	localparam int LVW  = $clog2(STACK_DEPTH + 1);
	localparam int TCW  = $clog2(WARP_WIDTH + 1);
	localparam int SDEP = NUM_WARPS * STACK_DEPTH;
	localparam int SAW  = (SDEP > 1) ? $clog2(SDEP) : 1;

	typedef struct packed {
		logic [TCW-1:0]        thr;
		logic [WARP_WIDTH-1:0] mask;
		logic [LVW-1:0]        lvl;
	} rec_t;

	function automatic logic [WARP_WIDTH-1:0] ones_of(input logic [TCW-1:0] n);
		return ~({WARP_WIDTH{1'b1}} << n);
	endfunction

	// beat fields
	logic [CMD_W-1:0]  in_cmd;
	logic [WARP_W-1:0] in_warp;
	logic [COND_W-1:0] in_cond;
	logic [TCNT_W-1:0] in_tcnt;
	logic [TIDX_W-1:0] in_tidx;

	assign in_cmd  = s_tdata[IN_WARP_LO-1:IN_CMD_LO];
	assign in_warp = s_tdata[IN_COND_LO-1:IN_WARP_LO];
	assign in_cond = s_tdata[IN_TCNT_LO-1:IN_COND_LO];
	assign in_tcnt = s_tdata[IN_TIDX_LO-1:IN_TCNT_LO];
	assign in_tidx = s_tdata[IN_BITS-1:IN_TIDX_LO];

	logic [CMD_W-1:0]      cmd_q;
	logic [WIDX-1:0]       idx_q;
	logic                  inrange_q;
	logic [WARP_WIDTH-1:0] cond_q;
	logic [TCNT_W-1:0]     tcnt_q;
	logic [TIDX_W-1:0]     tidx_q;

	rec_t                  rec_mem [NUM_WARPS];
	rec_t                  rec_rd_q;
	logic [WARP_WIDTH-1:0] stk_mem [SDEP];
	logic [WARP_WIDTH-1:0] stk_rd_q;

	logic [NUM_WARPS-1:0]  vld_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CFG_W-1:0]      cfg_depth_q;

	rec_t                  res_rec_q;
	logic                  res_ok_q;
	logic                  res_div_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q     <= in_cmd;
			idx_q     <= WIDX'(in_warp);
			inrange_q <= ({3'b000, in_warp} < 7'(NUM_WARPS));
			cond_q    <= WARP_WIDTH'(in_cond);
			tcnt_q    <= in_tcnt;
			tidx_q    <= in_tidx;
			rec_rd_q  <= rec_mem[WIDX'(in_warp)];
		end
	end

	// execute
	logic                  valid_w;
	logic                  is_init;
	logic                  is_branch;
	logic                  is_join;
	logic                  is_compute;
	logic [TCW-1:0]        tc_sat;
	logic [WARP_WIDTH-1:0] nm;
	logic [6:0]            lim;
	logic                  push_ok;
	logic                  div_w;
	logic                  push_w;
	rec_t                  rec_nx;
	logic                  rec_we_x;
	rec_t                  rec_pop;
	rec_t                  rec_wd;
	logic                  rec_we;
	logic [SAW-1:0]        stk_base;
	logic [SAW-1:0]        push_addr;
	logic [SAW-1:0]        pop_addr;

	assign valid_w    = inrange_q && vld_q[idx_q];
	assign is_init    = (cmd_q == CMD_INIT);
	assign is_branch  = (cmd_q == CMD_BRANCH);
	assign is_join    = (cmd_q == CMD_JOIN);
	assign is_compute = (cmd_q == CMD_COMPUTE);

	assign tc_sat = (tcnt_q > TCNT_W'(WARP_WIDTH)) ? TCW'(WARP_WIDTH) : TCW'(tcnt_q);
	assign nm     = rec_rd_q.mask & cond_q & ones_of(rec_rd_q.thr);

	assign lim     = (7'(cfg_depth_q) > 7'(STACK_DEPTH)) ? 7'(STACK_DEPTH) : 7'(cfg_depth_q);
	assign push_ok = (7'(rec_rd_q.lvl) < lim);

	assign div_w  = is_branch && valid_w && (nm != rec_rd_q.mask) && (nm != '0);
	assign push_w = is_branch && valid_w && push_ok;
	assign sts.pop_req = is_join && valid_w && (rec_rd_q.lvl != '0);

	assign stk_base  = SAW'(SAW'(idx_q) * SAW'(STACK_DEPTH));
	assign push_addr = stk_base + SAW'(rec_rd_q.lvl);
	assign pop_addr  = stk_base + SAW'(rec_rd_q.lvl - LVW'(1));

	always_comb begin
		rec_nx = rec_rd_q;
		rec_we_x = 1'b0;
		priority if (inrange_q && is_init) begin
			rec_nx.thr  = tc_sat;
			rec_nx.mask = ones_of(tc_sat);
			rec_nx.lvl  = '0;
			rec_we_x = 1'b1;
		end else if (valid_w && is_branch) begin
			rec_nx.mask = nm;
			rec_nx.lvl  = push_ok ? LVW'(rec_rd_q.lvl + LVW'(1)) : rec_rd_q.lvl;
			rec_we_x = 1'b1;
		end else if (valid_w && is_compute) begin
			rec_nx.mask = nm;
			rec_we_x = 1'b1;
		end else begin
			rec_we_x = 1'b0;
		end
	end

	always_comb begin
		rec_pop = rec_rd_q;
		rec_pop.mask = stk_rd_q;
		rec_pop.lvl  = LVW'(rec_rd_q.lvl - LVW'(1));
	end

	assign rec_wd = cmd.pop ? rec_pop : rec_nx;
	assign rec_we = (cmd.exec && rec_we_x) || cmd.pop;

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[idx_q] <= rec_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && push_w) begin
			stk_mem[push_addr] <= rec_rd_q.mask;
		end
		if (cmd.exec && sts.pop_req) begin
			stk_rd_q <= stk_mem[pop_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			cnt_q       <= '0;
			cfg_depth_q <= CFG_DEPTH_RST;
			res_ok_q    <= 1'b0;
			res_div_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_depth_q <= cfg_wr_data;
			end
			if (cmd.exec && inrange_q && is_init) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (cmd.exec && div_w) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.exec) begin
				res_ok_q  <= inrange_q && (is_init || vld_q[idx_q]);
				res_div_q <= div_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.pop) begin
			res_rec_q <= rec_wd;
		end
	end

	// result beat
	logic [MASK_W-1:0]  o_mask;
	logic [DEPTH_W-1:0] o_depth;

	assign o_mask  = res_ok_q ? MASK_W'(res_rec_q.mask) : '0;
	assign o_depth = res_ok_q ? DEPTH_W'(res_rec_q.lvl) : '0;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata <= M_DATA_W'({o_depth, cnt_q, res_div_q, res_ok_q, o_mask[tidx_q], o_mask});
		end
	end

	`SDMS_ASSERT(a_cnt_step, clk, arst_n, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CNT_W'(1)))
	`SDMS_ASSERT(a_div_needs_ok, clk, arst_n, res_div_q |-> res_ok_q)
	`SDMS_NEVER(a_lvl_bound, clk, arst_n, rec_we && (rec_wd.lvl > LVW'(STACK_DEPTH)))

endmodule

// ===== hdl/simt_divergence_mask_stack_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// simt_divergence_mask_stack_core
// Per-warp SIMT active-mask controller with a reconvergence stack.
// ---------------------------------------------------------------------------
// Usage:
//   s_* : command beats (init, branch, join, compute, query) for one warp.
//   m_* : one result beat per command: mask, thread bit, warp ok, diverged,
//         running divergence count and stack depth.
//   cfg_wr_en / cfg_wr_data : stack depth limit, write only while idle.
// Flow: m_tvalid rises once the beat has passed the execute step and the
//   result load; a join that pops a saved mask adds a pop step in between
//   (extra read of the saved-mask memory). A new beat is taken only after the
//   last one's result load; the record memory read, the execute step and the result load run in sequence.
// A finished result sits in the output register, so the next beat is
//   taken while it waits; if m_tready stays low the second result waits in
//   the datapath and s_tready stays low until the output register frees.
// Reset: all warps invalid, divergence count zero, depth limit 32. No
//   clearing pass: the record and saved-mask memory contents are used only
//   after being written.
// ---------------------------------------------------------------------------
module simt_divergence_mask_stack_core #(
	parameter int NUM_WARPS   = sdms_pkg::NUM_WARPS_DEF,
	parameter int WARP_WIDTH  = sdms_pkg::WARP_WIDTH_DEF,
	parameter int STACK_DEPTH = sdms_pkg::STACK_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// command, warp, conditions, thread_count, thread_index
	input  logic [sdms_pkg::S_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// active_mask, thread_active, warp_ok, diverged, divergence_total, depth_now
	output logic [sdms_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                          cfg_wr_en,
	input  logic [sdms_pkg::CFG_W-1:0]    cfg_wr_data
);
	import sdms_pkg::*;

	sdms_cmd_t cmd;
	sdms_sts_t sts;

	sdms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sdms_dp #(
		.NUM_WARPS   (NUM_WARPS),
		.WARP_WIDTH  (WARP_WIDTH),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tdata     (s_tdata),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

// ===== test/simt_divergence_mask_stack_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// simt_divergence_mask_stack_core_test
// Drives command beats into the warp mask stack core and checks each result
// beat against a behavioral model of the per-warp masks, thread counts and
// reconvergence stacks. Directed beats cover the edge cases first. Random
// traffic follows in phases that vary the depth limit and the back-pressure.
// ---------------------------------------------------------------------------
module simt_divergence_mask_stack_core_test;
	import sdms_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASES = 8;
	localparam int PHASE_BEATS = 225;

	// fields from the lowest bit up: command, warp, conditions, thread_count, thread_index
	typedef struct packed {
		logic [TIDX_W-1:0] thread_index;
		logic [TCNT_W-1:0] thread_count;
		logic [COND_W-1:0] conditions;
		logic [WARP_W-1:0] warp;
		logic [CMD_W-1:0]  command;
	} warp_cmd_t;

	// fields from the lowest bit up: active_mask, thread_active, warp_ok, diverged,
	// divergence_total, depth_now
	typedef struct packed {
		logic [DEPTH_W-1:0] depth_now;
		logic [CNT_W-1:0]   divergence_total;
		logic               diverged;
		logic               warp_ok;
		logic               thread_active;
		logic [MASK_W-1:0]  active_mask;
	} warp_result_t;

	class mask_stack_scoreboard;
		logic [CFG_W-1:0]   depth_limit;
		bit                 warp_valid [NUM_WARPS_DEF];
		logic [TCNT_W-1:0]  warp_threads [NUM_WARPS_DEF];
		logic [MASK_W-1:0]  warp_mask [NUM_WARPS_DEF];
		logic [MASK_W-1:0]  saved_masks [NUM_WARPS_DEF][STACK_DEPTH_DEF];
		logic [DEPTH_W-1:0] stack_level [NUM_WARPS_DEF];
		logic [CNT_W-1:0]   divergence_count;
		warp_result_t       pending_results [$];
		int                 failures;
		int                 results_seen;

		function new();
			depth_limit = CFG_DEPTH_RST;
			divergence_count = '0;
			failures = 0;
			results_seen = 0;
			for (int i = 0; i < NUM_WARPS_DEF; i++) begin
				warp_valid[i] = 1'b0;
				warp_threads[i] = '0;
				warp_mask[i] = '0;
				stack_level[i] = '0;
			end
		endfunction

		function logic [MASK_W-1:0] lane_span(input logic [TCNT_W-1:0] n);
			return (n >= WARP_WIDTH_DEF) ? '1 : (MASK_W'(1) << n) - MASK_W'(1);
		endfunction

		function void note_failure(input string msg);
			failures++;
			if (failures <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void note_command(input warp_cmd_t c);
			warp_result_t r;
			logic [MASK_W-1:0] narrowed;
			logic [DEPTH_W-1:0] limit;
			logic [TCNT_W-1:0] count;
			int w;
			w = int'(c.warp);
			r = '0;
			if (c.command == CMD_INIT) begin
				count = (c.thread_count > WARP_WIDTH_DEF) ? TCNT_W'(WARP_WIDTH_DEF) : c.thread_count;
				warp_valid[w] = 1'b1;
				warp_threads[w] = count;
				warp_mask[w] = lane_span(count);
				stack_level[w] = '0;
			end else if (warp_valid[w]) begin
				limit = (depth_limit > STACK_DEPTH_DEF) ? DEPTH_W'(STACK_DEPTH_DEF) : depth_limit;
				narrowed = warp_mask[w] & c.conditions & lane_span(warp_threads[w]);
				case (c.command)
					CMD_BRANCH: begin
						if (narrowed != warp_mask[w] && narrowed != '0) begin
							r.diverged = 1'b1;
							divergence_count++;
						end
						if (stack_level[w] < limit) begin
							saved_masks[w][stack_level[w]] = warp_mask[w];
							stack_level[w]++;
						end
						warp_mask[w] = narrowed;
					end
					CMD_JOIN: begin
						if (stack_level[w] > 0) begin
							stack_level[w]--;
							warp_mask[w] = saved_masks[w][stack_level[w]];
						end
					end
					CMD_COMPUTE: warp_mask[w] = narrowed;
					default: ;
				endcase
			end
			if (warp_valid[w]) begin
				r.warp_ok = 1'b1;
				r.active_mask = warp_mask[w];
				r.depth_now = stack_level[w];
			end
			r.thread_active = r.active_mask[c.thread_index];
			r.divergence_total = divergence_count;
			pending_results = {pending_results, r};
		endfunction

		function void check_result(input warp_result_t got);
			warp_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("result %0d arrived with nothing pending", results_seen));
				return;
			end
			want = pending_results.pop_front();
			if (got.active_mask !== want.active_mask || got.thread_active !== want.thread_active ||
				got.warp_ok !== want.warp_ok || got.diverged !== want.diverged ||
				got.divergence_total !== want.divergence_total || got.depth_now !== want.depth_now)
				note_failure($sformatf({"result %0d mismatch (exp/got): mask %h/%h act %b/%b ",
					"ok %b/%b div %b/%b total %0d/%0d depth %0d/%0d"}, results_seen,
					want.active_mask, got.active_mask, want.thread_active, got.thread_active,
					want.warp_ok, got.warp_ok, want.diverged, got.diverged,
					want.divergence_total, got.divergence_total, want.depth_now, got.depth_now));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]    cfg_wr_data = '0;

	mask_stack_scoreboard board;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int beats_in = 0;
	int quiet_cycles = 0;

	logic [CFG_W-1:0] phase_limit [PHASES] = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd5, 6'd33, 6'd31, 6'd16};
	int phase_send_idle [PHASES] = '{0, 73, 0, 34, 0, 73, 0, 34};
	int phase_stall [PHASES] = '{0, 0, 73, 34, 0, 0, 73, 34};

	simt_divergence_mask_stack_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(warp_result_t'(m_tdata[OUT_BITS-1:0]));
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// called and returns at a falling edge; valid stays up for back-to-back beats
	task automatic issue(input logic [CMD_W-1:0] op, input logic [WARP_W-1:0] w,
		input logic [COND_W-1:0] cond, input logic [TCNT_W-1:0] tc,
		input logic [TIDX_W-1:0] idx);
		warp_cmd_t c;
		c.command = op;
		c.warp = w;
		c.conditions = cond;
		c.thread_count = tc;
		c.thread_index = idx;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = S_DATA_W'(c);
		do @(posedge clk); while (!s_tready);
		board.note_command(c);
		beats_in++;
		@(negedge clk);
	endtask

	task automatic await_idle();
		s_tvalid = 1'b0;
		while (board.pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_depth_limit(input logic [CFG_W-1:0] v);
		await_idle();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		board.depth_limit = v;
	endtask

	function automatic logic [TCNT_W-1:0] rand_threads();
		return ($urandom_range(9) == 0) ? TCNT_W'($urandom_range(63, 33))
			: TCNT_W'($urandom_range(32));
	endfunction

	function automatic logic [COND_W-1:0] rand_conditions();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3, 4: return $urandom | $urandom;
			default: return $urandom;
		endcase
	endfunction

	// nested branch/join regions per warp, deep pushes past the limit, and noise
	task automatic run_random_traffic(input int target);
		logic [WARP_W-1:0] w;
		int kind;
		int k;
		while (beats_in < target) begin
			w = WARP_W'($urandom_range(NUM_WARPS_DEF - 1));
			kind = $urandom_range(99);
			if (kind < 60) begin
				if ($urandom_range(3) == 0)
					issue(CMD_INIT, w, $urandom, rand_threads(), TIDX_W'($urandom_range(31)));
				k = $urandom_range(1, 6);
				repeat (k) begin
					issue(CMD_BRANCH, w, rand_conditions(), TCNT_W'($urandom),
						TIDX_W'($urandom_range(31)));
					if ($urandom_range(3) == 0)
						issue(CMD_W'($urandom_range(CMD_COMPUTE, CMD_UNUSED_HI)), w,
							rand_conditions(), TCNT_W'($urandom), TIDX_W'($urandom_range(31)));
				end
				repeat (k + $urandom_range(1))
					issue(CMD_JOIN, w, $urandom, TCNT_W'($urandom), TIDX_W'($urandom_range(31)));
			end else if (kind < 70) begin
				if ($urandom_range(1) == 0)
					issue(CMD_INIT, w, $urandom, rand_threads(), TIDX_W'($urandom_range(31)));
				k = $urandom_range(30, 36);
				repeat (k)
					issue(CMD_BRANCH, w, rand_conditions(), TCNT_W'($urandom),
						TIDX_W'($urandom_range(31)));
				repeat (k + 1)
					issue(CMD_JOIN, w, $urandom, TCNT_W'($urandom), TIDX_W'($urandom_range(31)));
			end else begin
				issue(CMD_W'($urandom_range(CMD_UNUSED_HI)), w, rand_conditions(),
					($urandom_range(1) == 0) ? rand_threads() : TCNT_W'($urandom),
					TIDX_W'($urandom_range(31)));
			end
		end
	endtask

	initial begin
		board = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// warp never initialized
		issue(CMD_QUERY, 4'd3, '1, '1, 5'd31);
		issue(CMD_BRANCH, 4'd3, '1, '0, 5'd0);
		issue(CMD_JOIN, 4'd3, '0, '0, 5'd0);
		issue(CMD_COMPUTE, 4'd3, '1, '1, 5'd0);
		// thread count saturates, then zero threads
		issue(CMD_INIT, 4'd0, '0, '1, 5'd31);
		issue(CMD_INIT, 4'd15, '1, '0, 5'd0);
		issue(CMD_BRANCH, 4'd15, '1, '0, 5'd31);
		// split, uniform branch, empty mask, then pops down past an empty stack
		issue(CMD_INIT, 4'd1, '0, 6'd32, 5'd16);
		issue(CMD_BRANCH, 4'd1, 32'h0000_FFFF, '0, 5'd16);
		issue(CMD_BRANCH, 4'd1, '1, '0, 5'd15);
		issue(CMD_BRANCH, 4'd1, '0, '0, 5'd0);
		repeat (4) issue(CMD_JOIN, 4'd1, '1, '1, 5'd31);
		issue(CMD_COMPUTE, 4'd1, 32'hF0F0_F0F0, '0, 5'd4);
		issue(CMD_QUERY, 4'd1, '0, '0, 5'd3);
		for (int op = CMD_QUERY + 1; op <= CMD_UNUSED_HI; op++)
			issue(CMD_W'(op), 4'd1, '1, '1, 5'd7);
		// reinit of a live warp and a single-thread warp
		issue(CMD_INIT, 4'd1, '0, 6'd5, 5'd4);
		issue(CMD_INIT, 4'd2, '1, 6'd1, 5'd0);

		for (int p = 0; p < PHASES; p++) begin
			write_depth_limit(phase_limit[p]);
			send_idle_pct = phase_send_idle[p];
			stall_pct = phase_stall[p];
			run_random_traffic(beats_in + PHASE_BEATS);
		end

		await_idle();
		if (board.failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sdms_pkg.sv
hdl/sdms_ctrl.sv
hdl/sdms_dp.sv
hdl/simt_divergence_mask_stack_core.sv
test/simt_divergence_mask_stack_core_test.sv
